// ===== sv/lbs_pkg.sv =====
// Shared constants and types for the linear blend skinning block.
// No dependencies; used by all modules through scoped names.
package lbs_pkg;
	localparam int NumJoints     = 64;
	localparam int MaxInfluences = 8;
	localparam int PaletteWords  = NumJoints * 12;
	localparam int PalAw         = $clog2(PaletteWords);

	localparam logic [1:0] CmdPalette   = 2'd0;
	localparam logic [1:0] CmdVector    = 2'd1;
	localparam logic [1:0] CmdInfluence = 2'd2;

	localparam logic [1:0] KindPos = 2'd0;
	localparam logic [1:0] KindNrm = 2'd1;
	localparam logic [1:0] KindTan = 2'd2;
	localparam logic [1:0] SelNone = 2'd3;

	typedef logic signed [31:0] word_t;
	typedef logic signed [49:0] dot_t;
	typedef logic signed [63:0] acc_t;

	// saturate a wide signed value to 32 bits
	function automatic word_t sat32(input acc_t x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage

// ===== sv/lbs_palette_ram.sv =====
// Palette memory of 3x4 joint matrices, one write and one registered read port.
// Depends on lbs_pkg.
module lbs_palette_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [lbs_pkg::PalAw-1:0] waddr,
	input  lbs_pkg::word_t           wdata,
	input  logic [lbs_pkg::PalAw-1:0] raddr,
	output lbs_pkg::word_t           rdata
);
	lbs_pkg::word_t mem [lbs_pkg::PaletteWords];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/lbs_mac.sv =====
// Shared multiply-accumulate unit: one matrix word times one vector word per cycle,
// summed into a row dot product with the translation path. Depends on lbs_pkg.
module lbs_mac (
	input  logic           clk,
	input  logic           clr_dot,
	input  logic           do_mul,
	input  logic           do_tr,
	input  lbs_pkg::word_t m,
	input  lbs_pkg::word_t v,
	output lbs_pkg::dot_t  dot
);
	logic signed [63:0] prod_s1;
	lbs_pkg::dot_t dot_q;

	// multiply stage, then floor-shift and add into the dot sum; or clear it, or add the translation word
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(m) * 64'(v);
		if (clr_dot) dot_q <= '0;
		else if (do_mul) dot_q <= dot_q + 50'(prod_s1 >>> 16);
		else if (do_tr) dot_q <= dot_q + 50'(m);
	end
	assign dot = dot_q;
endmodule

// ===== sv/linear_blend_skinning_top.sv =====
// Linear blend skinning top; depends on lbs_pkg, lbs_palette_ram and lbs_mac.
// Palette, vector and ignored words are accepted one per cycle while the block is idle.
// An influence holds in_ready low through 9 rows of 3 or 4 columns, each column in
// read, multiply and add states, then weight and accumulate states per row; one MAC
// does the columns. A vertex's three results follow its last influence and leave one
// per accepted output word. Reset clears vectors, accumulators, count, register (4).
module linear_blend_skinning_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [9:0]  palette_address,
	input  logic signed [31:0] palette_value,
	input  logic [1:0]  vector_select,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic [15:0] weight,
	input  logic [5:0]  joint_index,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  vector_kind,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic        last
);
	localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StMul = 3'd2,
		StAdd = 3'd3, StWgt = 3'd4, StAcc = 3'd5, StOut = 3'd6;

	logic [2:0] state_q;
	logic [3:0] ipv_q;
	logic [2:0] cnt_q;
	lbs_pkg::word_t vv_q [9];
	lbs_pkg::acc_t acc_q [9];
	logic [1:0] vec_q;      // vector being transformed
	logic [1:0] mrow_q;     // matrix row
	logic [1:0] col_q;      // 0..3, 3 = translation
	logic [16:0] w_q;
	logic [5:0] joint_q;
	logic [1:0] ocnt_q;
	logic signed [63:0] wp_s1;
	logic ok_q;

	logic in_fire, out_fire;
	logic [lbs_pkg::PalAw-1:0] raddr, waddr;
	lbs_pkg::word_t rdata, vsel;
	logic pal_we;
	lbs_pkg::dot_t dot;
	logic [3:0] aidx, vidx, oidx;
	logic [1:0] lastcol;
	logic clr_dot, do_mul, do_tr;
	logic [3:0] n_eff;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == StIdle);

	// palette address from joint, row and column; operand and accumulator indexes
	always_comb begin
		raddr = lbs_pkg::PalAw'(joint_q * 12 + mrow_q * 4 + col_q);
		waddr = palette_address[lbs_pkg::PalAw-1:0];
		pal_we = in_fire && command == lbs_pkg::CmdPalette
			&& 32'(palette_address) < lbs_pkg::PaletteWords;
		aidx = 4'(vec_q) * 4'd3 + 4'(mrow_q);
		vidx = 4'(vec_q) * 4'd3 + 4'(col_q);
		oidx = 4'(ocnt_q) * 4'd3;
		vsel = (col_q == 2'd3) ? '0 : vv_q[vidx];
		lastcol = (vec_q == lbs_pkg::KindPos) ? 2'd3 : 2'd2;
	end

	lbs_palette_ram u_ram (.clk, .we(pal_we), .waddr, .wdata(palette_value),
		.raddr, .rdata);

	lbs_mac u_mac (.clk, .clr_dot, .do_mul, .do_tr, .m(rdata), .v(vsel), .dot);

	// read data arrives in StMul, product in StAdd; translation word is added directly
	assign clr_dot = (state_q == StRead) && col_q == 2'd0;
	assign do_mul = (state_q == StAdd) && col_q != 2'd3;
	assign do_tr = (state_q == StAdd) && col_q == 2'd3;

	assign n_eff = (ipv_q == 4'd0) ? 4'd1 :
		(ipv_q > 4'(lbs_pkg::MaxInfluences)) ? 4'(lbs_pkg::MaxInfluences) : ipv_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ipv_q <= 4'd4;
			cnt_q <= '0;
			ocnt_q <= '0;
			for (int i = 0; i < 9; i++) begin
				vv_q[i] <= '0;
				acc_q[i] <= '0;
			end
			vec_q <= '0; mrow_q <= '0; col_q <= '0;
			ok_q <= 1'b0; w_q <= '0; joint_q <= '0;
		end else begin
			if (cfg_we) ipv_q <= cfg_wdata;
			unique case (state_q)
				StIdle: if (in_fire) begin
					if (command == lbs_pkg::CmdVector && vector_select != lbs_pkg::SelNone) begin
						vv_q[4'(vector_select) * 4'd3]         <= vec_x;
						vv_q[4'(vector_select) * 4'd3 + 4'd1] <= vec_y;
						vv_q[4'(vector_select) * 4'd3 + 4'd2] <= vec_z;
					end else if (command == lbs_pkg::CmdInfluence) begin
						w_q <= (weight > 16'd32768) ? 17'd32768 : {1'b0, weight};
						joint_q <= joint_index;
						ok_q <= weight != 16'd0
							&& 32'(joint_index) < lbs_pkg::NumJoints;
						vec_q <= lbs_pkg::KindPos;
						mrow_q <= '0;
						col_q <= '0;
						state_q <= StRead;
					end
				end
				StRead: begin
					state_q <= StMul;
				end
				StMul: begin
					state_q <= StAdd;
				end
				StAdd: begin
					// next column, or weight the finished row
					if (col_q == lastcol) begin
						col_q <= '0;
						state_q <= StWgt;
					end else begin
						col_q <= col_q + 2'd1;
						state_q <= StRead;
					end
				end
				StWgt: begin
					state_q <= StAcc;
				end
				StAcc: begin
					if (ok_q) acc_q[aidx] <= acc_q[aidx] + (wp_s1 >>> 15);
					if (mrow_q != 2'd2) begin
						mrow_q <= mrow_q + 2'd1;
						state_q <= StRead;
					end else if (vec_q != lbs_pkg::KindTan) begin
						mrow_q <= '0;
						vec_q <= vec_q + 2'd1;
						state_q <= StRead;
					end else begin
						mrow_q <= '0;
						vec_q <= lbs_pkg::KindPos;
						if (4'(cnt_q) + 4'd1 < n_eff) begin
							cnt_q <= cnt_q + 3'd1;
							state_q <= StIdle;
						end else begin
							cnt_q <= '0;
							ocnt_q <= lbs_pkg::KindPos;
							state_q <= StOut;
						end
					end
				end
				StOut: if (out_fire) begin
					if (ocnt_q == lbs_pkg::KindTan) begin
						for (int i = 0; i < 9; i++) acc_q[i] <= '0;
						ocnt_q <= lbs_pkg::KindPos;
						state_q <= StIdle;
					end else begin
						ocnt_q <= ocnt_q + 2'd1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// weight the finished row dot product
	always_ff @(posedge clk) begin
		if (state_q == StWgt) wp_s1 <= 64'(dot) * 64'($signed({1'b0, w_q}));
	end

	// output words
	assign out_valid = (state_q == StOut);
	assign vector_kind = ocnt_q;
	assign last = (ocnt_q == lbs_pkg::KindTan);
	assign out_x = lbs_pkg::sat32(acc_q[oidx]);
	assign out_y = lbs_pkg::sat32(acc_q[oidx + 4'd1]);
	assign out_z = lbs_pkg::sat32(acc_q[oidx + 4'd2]);
endmodule

// ===== tb/tb_linear_blend_skinning_top.sv =====
// Testbench for linear_blend_skinning_top: random and directed palette, vector and influence words.
// Predicts skinned vertices in a local model and checks every output word; needs lbs_pkg.
`timescale 1ns / 1ps

module tb_linear_blend_skinning_top;
	localparam logic [1:0] CmdUnused = 2'd3;
	localparam int SettleCycles = 200;
	localparam int IdleLimit    = 20000;

	typedef struct {
		logic [1:0]  cmd;
		logic [9:0]  addr;
		lbs_pkg::word_t pval;
		logic [1:0]  sel;
		lbs_pkg::word_t x, y, z;
		logic [15:0] w;
		logic [5:0]  j;
	} skin_word_t;

	typedef struct {
		logic [1:0] kind;
		lbs_pkg::word_t x, y, z;
		logic       last;
	} skinned_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = '0;
	logic [9:0] palette_address = '0;
	logic signed [31:0] palette_value = '0;
	logic [1:0] vector_select = '0;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic [15:0] weight = '0;
	logic [5:0] joint_index = '0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] vector_kind;
	logic signed [31:0] out_x, out_y, out_z;
	logic last;

	linear_blend_skinning_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .palette_address(palette_address), .palette_value(palette_value),
		.vector_select(vector_select), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.weight(weight), .joint_index(joint_index),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.vector_kind(vector_kind), .out_x(out_x), .out_y(out_y), .out_z(out_z), .last(last)
	);

	// local copy of the block state
	longint palette_mem [lbs_pkg::PaletteWords];
	longint vertex_regs [9];
	longint blend_acc [9];
	int unsigned blend_count;
	int unsigned influences_reg;

	skin_word_t pending_words[$];
	skinned_vec_t expected_vecs[$];
	int errors = 0;
	int idle_cycles = 0;
	logic in_taken = 1'b0;

	// stimulus bookkeeping: which palette words and joints are safe to read
	bit word_written [lbs_pkg::PaletteWords];
	int ready_joints[$];

	initial begin
		forever #2 clk = ~clk;
	end

	// add one weighted joint transform into the accumulators
	function automatic void blend_joint(int unsigned joint, longint w);
		int unsigned base;
		longint dot;
		base = joint * 12;
		for (int v = 0; v < 3; v++) begin
			for (int r = 0; r < 3; r++) begin
				dot = 0;
				for (int c = 0; c < 3; c++)
					dot += (palette_mem[base + r * 4 + c] * vertex_regs[v * 3 + c]) >>> 16;
				if (v == 0)
					dot += palette_mem[base + r * 4 + 3];
				blend_acc[v * 3 + r] += (dot * w) >>> 15;
			end
		end
	endfunction

	function automatic lbs_pkg::word_t clamp_word(longint a);
		if (a > 64'sd2147483647) return 32'sh7fffffff;
		if (a < -64'sd2147483648) return 32'sh80000000;
		return a[31:0];
	endfunction

	// advance the local model by one accepted word
	function automatic void skin_predict(skin_word_t s);
		int unsigned n;
		longint w;
		skinned_vec_t o;
		case (s.cmd)
			lbs_pkg::CmdPalette: if (s.addr < lbs_pkg::PaletteWords) palette_mem[s.addr] = s.pval;
			lbs_pkg::CmdVector: if (s.sel != lbs_pkg::SelNone) begin
				vertex_regs[s.sel * 3 + 0] = s.x;
				vertex_regs[s.sel * 3 + 1] = s.y;
				vertex_regs[s.sel * 3 + 2] = s.z;
			end
			lbs_pkg::CmdInfluence: begin
				n = influences_reg;
				if (n < 1) n = 1;
				if (n > lbs_pkg::MaxInfluences) n = lbs_pkg::MaxInfluences;
				w = (s.w > 16'd32768) ? 32768 : s.w;
				if (w != 0 && s.j < lbs_pkg::NumJoints)
					blend_joint(s.j, w);
				if (blend_count + 1 < n) begin
					blend_count = (blend_count + 1) & 7;
				end else begin
					for (int k = 0; k < 3; k++) begin
						o.kind = k[1:0];
						o.x = clamp_word(blend_acc[k * 3 + 0]);
						o.y = clamp_word(blend_acc[k * 3 + 1]);
						o.z = clamp_word(blend_acc[k * 3 + 2]);
						o.last = (k == 2);
						expected_vecs = {expected_vecs, o};
					end
					foreach (blend_acc[i]) blend_acc[i] = 0;
					blend_count = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// sample handshakes, predict, check, and watch for a hang
	always @(posedge clk) begin
		skin_word_t s;
		skinned_vec_t e;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (cfg_we)
				influences_reg = cfg_wdata;
			if (in_valid && in_ready) begin
				s.cmd = command; s.addr = palette_address; s.pval = palette_value;
				s.sel = vector_select; s.x = vec_x; s.y = vec_y; s.z = vec_z;
				s.w = weight; s.j = joint_index;
				skin_predict(s);
			end
			if (out_valid && out_ready) begin
				if (expected_vecs.size() == 0) begin
					$error("unexpected output word kind %0d", vector_kind);
					errors++;
				end else begin
					e = expected_vecs.pop_front();
					if (vector_kind !== e.kind) begin
						$error("vector_kind expected %0d got %0d", e.kind, vector_kind);
						errors++;
					end
					if (out_x !== e.x) begin
						$error("out_x expected %0d got %0d", e.x, out_x);
						errors++;
					end
					if (out_y !== e.y) begin
						$error("out_y expected %0d got %0d", e.y, out_y);
						errors++;
					end
					if (out_z !== e.z) begin
						$error("out_z expected %0d got %0d", e.z, out_z);
						errors++;
					end
					if (last !== e.last) begin
						$error("last expected %0d got %0d", e.last, last);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// send words in bursts with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		skin_word_t s;
		if (arst_n) begin
			if (in_valid && in_taken) begin
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!in_valid || in_taken) begin
				if (gap_left > 0 || pending_words.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					s = pending_words.pop_front();
					in_valid <= 1'b1;
					command <= s.cmd; palette_address <= s.addr; palette_value <= s.pval;
					vector_select <= s.sel; vec_x <= s.x; vec_y <= s.y; vec_z <= s.z;
					weight <= s.w; joint_index <= s.j;
				end
			end
		end
	end

	// stall the output at a ready percentage (100, 60 or 20) that is redrawn at random
	int ready_pct = 100;
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 64 == 0)
			case ($urandom_range(0, 2))
				0: ready_pct = 100;
				1: ready_pct = 60;
				default: ready_pct = 20;
			endcase
		out_ready <= ($urandom_range(0, 99) < ready_pct);
	end

	function automatic skin_word_t blank_word(logic [1:0] cmd);
		skin_word_t s;
		s.cmd = cmd; s.addr = '0; s.pval = '0; s.sel = '0;
		s.x = '0; s.y = '0; s.z = '0; s.w = '0; s.j = '0;
		s.addr = 10'($urandom); s.pval = $urandom; s.sel = 2'($urandom_range(0, 2));
		return s;
	endfunction

	// queue a palette word and note when a whole joint becomes readable
	function automatic void push_palette(int unsigned addr, lbs_pkg::word_t val);
		skin_word_t s;
		int unsigned jt;
		bit full;
		s = blank_word(lbs_pkg::CmdPalette);
		s.addr = addr[9:0]; s.pval = val;
		pending_words = {pending_words, s};
		if (addr < lbs_pkg::PaletteWords) begin
			word_written[addr] = 1'b1;
			jt = addr / 12;
			full = 1'b1;
			for (int i = 0; i < 12; i++) full &= word_written[jt * 12 + i];
			if (full && !(jt inside {ready_joints})) ready_joints = {ready_joints, jt};
		end
	endfunction

	function automatic void push_vector(logic [1:0] sel, lbs_pkg::word_t x,
		lbs_pkg::word_t y, lbs_pkg::word_t z);
		skin_word_t s;
		s = blank_word(lbs_pkg::CmdVector);
		s.sel = sel; s.x = x; s.y = y; s.z = z;
		pending_words = {pending_words, s};
	endfunction

	function automatic void push_influence(logic [15:0] w, logic [5:0] j);
		skin_word_t s;
		s = blank_word(lbs_pkg::CmdInfluence);
		s.w = w; s.j = j;
		pending_words = {pending_words, s};
	endfunction

	// mostly modest Q16.16 values, sometimes anything
	function automatic lbs_pkg::word_t rand_q16();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	// well-formed skinning traffic with some noise mixed in
	task automatic random_phase(int count);
		int sent;
		int jt;
		logic [15:0] w;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 11))
				0: begin
					jt = $urandom_range(0, lbs_pkg::NumJoints - 1);
					for (int i = 0; i < 12; i++) push_palette(jt * 12 + i, rand_q16());
					sent += 12;
				end
				1, 2: begin
					push_vector(2'($urandom_range(0, 2)), rand_q16(), rand_q16(), rand_q16());
					sent++;
				end
				3: begin
					case ($urandom_range(0, 3))
						0: pending_words = {pending_words, blank_word(CmdUnused)};
						1: push_vector(lbs_pkg::SelNone, $urandom, $urandom, $urandom);
						2: push_palette($urandom_range(lbs_pkg::PaletteWords, 1023), $urandom);
						default: push_palette($urandom_range(0, lbs_pkg::PaletteWords - 1),
							rand_q16());
					endcase
					sent++;
				end
				default: begin
					if (ready_joints.size() > 0 && $urandom_range(0, 7) != 0) begin
						jt = ready_joints[$urandom_range(0, ready_joints.size() - 1)];
						case ($urandom_range(0, 4))
							0: w = 16'($urandom_range(32769, 65535));
							1: w = 16'd32768;
							default: w = 16'($urandom_range(1, 32768));
						endcase
					end else begin
						jt = $urandom_range(0, 63);
						w = '0;
					end
					push_influence(w, jt[5:0]);
					sent++;
				end
			endcase
		end
	endtask

	// wait until every word is taken and every result has come back
	task automatic drain();
		while (pending_words.size() != 0 || in_valid) @(posedge clk);
		while (expected_vecs.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_influences(logic [3:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [3:0] settings [6];
		foreach (palette_mem[i]) palette_mem[i] = 0;
		foreach (vertex_regs[i]) vertex_regs[i] = 0;
		foreach (blend_acc[i]) blend_acc[i] = 0;
		blend_count = 0;
		influences_reg = 4;

		// hold reset low, then release it between clock edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme matrix on the top joint, extreme vectors, ignored words
		for (int i = 0; i < 12; i++)
			push_palette((lbs_pkg::NumJoints - 1) * 12 + i,
				(i % 2) ? 32'sh80000000 : 32'sh7fffffff);
		push_palette(1023, 32'sh7fffffff);
		push_vector(lbs_pkg::KindPos, 32'sh7fffffff, 32'sh80000000, 32'sh0001_0000);
		push_vector(lbs_pkg::KindNrm, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		push_vector(lbs_pkg::KindTan, 32'sh0000_0001, 32'sh7fffffff, -32'sh0001_0000);
		push_vector(lbs_pkg::SelNone, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		pending_words = {pending_words, blank_word(CmdUnused)};
		push_influence(16'd32768, 6'd63);
		push_influence(16'hffff, 6'd63);
		push_influence(16'd0, 6'd5);
		push_influence(16'd1, 6'd63);
		drain();

		// several register settings, extremes among them
		settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd0};
		settings[5] = 4'($urandom_range(0, 15));
		foreach (settings[p]) begin
			write_influences(settings[p]);
			random_phase(20);
			drain();
		end

		if (errors == 0 && expected_vecs.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
